FILE: src/iphpe_pkg.sv
// ----------------------------------------------------------------------------
// iphpe_pkg
// Shared types, constants and helpers for the IPv4 header and port extractor.
// ----------------------------------------------------------------------------
package iphpe_pkg;

  // byte counter and field widths
  localparam int unsigned IdxW    = 7;
  localparam int unsigned HdrLenW = 6;

  // byte positions within the packet
  localparam logic [IdxW-1:0] IdxMax       = 7'd127;
  localparam logic [IdxW-1:0] TotLenHi     = 7'd2;
  localparam logic [IdxW-1:0] TotLenLo     = 7'd3;
  localparam logic [4:0]      SrcAddrWord  = 5'd3;   // bytes 12 to 15
  localparam logic [4:0]      DstAddrWord  = 5'd4;   // bytes 16 to 19
  localparam logic [IdxW-1:0] MinHdrBytes  = 7'd20;
  localparam logic [IdxW-1:0] PortBytes    = 7'd4;
  localparam logic [3:0]      IhlMask      = 4'hf;

  // output record
  typedef struct packed {
    logic [HdrLenW-1:0] header_bytes;
    logic [15:0]        dest_port;
    logic [15:0]        source_port;
    logic [31:0]        dest_address;
    logic [31:0]        source_address;
    logic [15:0]        total_length;
    logic               status;
  } rec_t;

  // replace one byte of a big-endian 32-bit word, sel 0 is the top byte
  function automatic logic [31:0] put_be32(logic [31:0] word, logic [1:0] sel,
                                           logic [7:0] b);
    logic [31:0] res;
    res = word;
    case (sel)
      2'd0:    res[31:24] = b;
      2'd1:    res[23:16] = b;
      2'd2:    res[15:8]  = b;
      default: res[7:0]   = b;
    endcase
    return res;
  endfunction

  // replace one byte of a big-endian 16-bit word, sel 0 is the top byte
  function automatic logic [15:0] put_be16(logic [15:0] word, logic sel,
                                           logic [7:0] b);
    logic [15:0] res;
    res = word;
    if (sel) begin
      res[7:0] = b;
    end else begin
      res[15:8] = b;
    end
    return res;
  endfunction

endpackage

FILE: src/iphpe_obuf.sv
// ----------------------------------------------------------------------------
// iphpe_obuf
// Two-slot output register with skid slot, decouples the record stream from
// the byte stream so a stalled receiver does not stop byte intake at once.
// ----------------------------------------------------------------------------
module iphpe_obuf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  iphpe_pkg::rec_t in_rec_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output iphpe_pkg::rec_t out_rec_o
);
  import iphpe_pkg::*;

  logic main_v_q, main_v_d;
  logic skid_v_q, skid_v_d;
  rec_t main_q, main_d;
  rec_t skid_q, skid_d;
  logic push, pop;

  assign in_ready_o  = !skid_v_q;
  assign out_valid_o = main_v_q;
  assign out_rec_o   = main_q;
  assign push        = in_valid_i && !skid_v_q;
  assign pop         = main_v_q && out_ready_i;

  // slot steering
  always_comb begin
    main_v_d = main_v_q;
    skid_v_d = skid_v_q;
    main_d   = main_q;
    skid_d   = skid_q;
    if (pop) begin
      if (skid_v_q) begin
        main_d   = skid_q;
        skid_v_d = 1'b0;
      end else begin
        main_v_d = push;
        main_d   = in_rec_i;
      end
    end else if (!main_v_q) begin
      main_v_d = push;
      main_d   = in_rec_i;
    end else if (push) begin
      skid_v_d = 1'b1;
      skid_d   = in_rec_i;
    end
  end

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  // payload slots
  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

FILE: src/ipv4_header_port_extractor_core.sv
// ----------------------------------------------------------------------------
// ipv4_header_port_extractor_core
// Extracts IPv4 header fields and transport ports from a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one packet byte per transaction in tdata, first header
//   byte first; tlast marks the final byte of the packet.
//   m_axis carries one record per packet: total length, addresses, ports and
//   header length in tdata, and in tuser a flag set when the packet was too
//   short to hold every field (missing bytes read as zero).
// Latency: the record is on m_axis the cycle after the last byte is
//   accepted when no earlier record is still waiting there.
// Throughput: one byte per cycle while s_axis_tready is high, set by the
//   single register stage of capture logic; consecutive packets may follow with no gap.
// Stall: records queue in a two-slot output register; s_axis_tready falls
//   only while both slots hold records the receiver has not taken.
// Reset: all capture state is cleared and the output slots are emptied; the next byte
//   accepted is taken as byte 0 of a packet.
// ----------------------------------------------------------------------------
module ipv4_header_port_extractor_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // data_byte
  input  logic         s_axis_tlast,   // last_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [119:0] m_axis_tdata,   // total_length, source_address,
                                       // dest_address, source_port,
                                       // dest_port, header_bytes, zero pad
  output logic         m_axis_tuser    // status
);
  import iphpe_pkg::*;

  logic [IdxW-1:0]    byte_index_q, byte_index_d;
  logic [HdrLenW-1:0] header_len_q, header_len_d;
  logic [15:0]        total_len_q, total_len_d;
  logic [31:0]        src_addr_q, src_addr_d;
  logic [31:0]        dst_addr_q, dst_addr_d;
  logic [15:0]        src_port_q, src_port_d;
  logic [15:0]        dst_port_q, dst_port_d;

  logic               s_accept;
  logic               rec_ready;
  logic [7:0]         port_off;
  logic [IdxW-1:0]    count;
  logic [IdxW-1:0]    need;
  logic [IdxW-1:0]    hl_plus;
  rec_t               rec;
  rec_t               out_rec;

  assign s_axis_tready = rec_ready;
  assign s_accept      = s_axis_tvalid && rec_ready;

  // field capture for the current byte
  always_comb begin
    header_len_d = header_len_q;
    total_len_d  = total_len_q;
    src_addr_d   = src_addr_q;
    dst_addr_d   = dst_addr_q;
    src_port_d   = src_port_q;
    dst_port_d   = dst_port_q;

    if (byte_index_q == '0) begin
      header_len_d = {s_axis_tdata[3:0] & IhlMask, 2'b00};
    end
    if (byte_index_q == TotLenHi) begin
      total_len_d[15:8] = s_axis_tdata;
    end
    if (byte_index_q == TotLenLo) begin
      total_len_d[7:0] = s_axis_tdata;
    end
    if (byte_index_q[IdxW-1:2] == SrcAddrWord) begin
      src_addr_d = put_be32(src_addr_q, byte_index_q[1:0], s_axis_tdata);
    end
    if (byte_index_q[IdxW-1:2] == DstAddrWord) begin
      dst_addr_d = put_be32(dst_addr_q, byte_index_q[1:0], s_axis_tdata);
    end

    // port window starts at the header length, also when it overlaps
    port_off = {1'b0, byte_index_q} - {2'b00, header_len_d};
    if (!port_off[7] && port_off[6:2] == '0) begin
      if (!port_off[1]) begin
        src_port_d = put_be16(src_port_q, port_off[0], s_axis_tdata);
      end else begin
        dst_port_d = put_be16(dst_port_q, port_off[0], s_axis_tdata);
      end
    end
  end

  // saturating byte count and short packet check
  always_comb begin
    count   = (byte_index_q == IdxMax) ? IdxMax : byte_index_q + 7'd1;
    hl_plus = {1'b0, header_len_d} + PortBytes;
    need    = (hl_plus < MinHdrBytes) ? MinHdrBytes : hl_plus;
  end

  // record assembly
  always_comb begin
    rec.header_bytes   = header_len_d;
    rec.dest_port      = dst_port_d;
    rec.source_port    = src_port_d;
    rec.dest_address   = dst_addr_d;
    rec.source_address = src_addr_d;
    rec.total_length   = total_len_d;
    rec.status         = (count < need);
  end

  // capture state, cleared after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q <= '0;
      header_len_q <= '0;
      total_len_q  <= '0;
      src_addr_q   <= '0;
      dst_addr_q   <= '0;
      src_port_q   <= '0;
      dst_port_q   <= '0;
    end else if (s_accept) begin
      if (s_axis_tlast) begin
        byte_index_q <= '0;
        header_len_q <= '0;
        total_len_q  <= '0;
        src_addr_q   <= '0;
        dst_addr_q   <= '0;
        src_port_q   <= '0;
        dst_port_q   <= '0;
      end else begin
        byte_index_q <= byte_index_d;
        header_len_q <= header_len_d;
        total_len_q  <= total_len_d;
        src_addr_q   <= src_addr_d;
        dst_addr_q   <= dst_addr_d;
        src_port_q   <= src_port_d;
        dst_port_q   <= dst_port_d;
      end
    end
  end

  assign byte_index_d = count;

  // output register
  iphpe_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid && s_axis_tlast),
    .in_ready_o  (rec_ready),
    .in_rec_i    (rec),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_rec_o   (out_rec)
  );

  // output packing
  assign m_axis_tdata = {2'b00, out_rec.header_bytes, out_rec.dest_port,
                         out_rec.source_port, out_rec.dest_address,
                         out_rec.source_address, out_rec.total_length};
  assign m_axis_tuser = out_rec.status;

`ifndef SYNTHESIS
  // intake stalls only with a record pending
  a_stall_has_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("byte intake stalled with no record pending");

  // last byte yields a record next cycle
  a_last_gives_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && s_axis_tlast) |=> m_axis_tvalid)
    else $error("no record after last byte");

  // counter restarts after each packet
  a_index_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && s_axis_tlast) |=> (byte_index_q == '0))
    else $error("byte counter not cleared at packet end");

  // counter steps by one below saturation
  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && !s_axis_tlast && byte_index_q != IdxMax)
      |=> (byte_index_q == $past(byte_index_q) + 7'd1))
    else $error("byte counter did not advance");
`endif

endmodule

FILE: verif/ipv4_header_port_extractor_core_tb.sv
// ----------------------------------------------------------------------------
// ipv4_header_port_extractor_core_tb
// Self-checking bench for the IPv4 header field and port extractor. Packet
// bytes are streamed in with random gaps while the record side stalls at
// random. A behavioural copy of the capture logic predicts each record and
// every record is checked field by field. A short directed table comes
// first, then randomised packets of varied header and packet length.
// ----------------------------------------------------------------------------
module ipv4_header_port_extractor_core_tb;
  import iphpe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ClkHalf    = 10;
  localparam int unsigned ByteTarget = 1300;
  localparam int unsigned SrcStart   = SrcAddrWord * 4;
  localparam int unsigned DstStart   = DstAddrWord * 4;

  // one row of the directed table
  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         typed;
    rec_t       rec;
  } stim_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = 8'h00;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [119:0] m_axis_tdata;
  logic         m_axis_tuser;

  // capture state of the packet in flight
  logic [IdxW-1:0]    pkt_pos;
  logic [HdrLenW-1:0] pkt_hlen;
  logic [15:0]        pkt_tot;
  logic [31:0]        pkt_saddr;
  logic [31:0]        pkt_daddr;
  logic [15:0]        pkt_sport;
  logic [15:0]        pkt_dport;

  rec_t      pending_recs[$];
  stim_row_t dir_rows[$];
  int        mismatches = 0;
  int        stall_left = 0;
  int        cyc = 0;
  bit        src_calm = 1'b0;

  ipv4_header_port_extractor_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  always #(ClkHalf) clk_i = ~clk_i;

  // gap length: mostly short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 2);
    if (r < 18) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  function automatic rec_t mk_rec(logic [15:0] tot, logic [31:0] sa, logic [31:0] da,
                                  logic [15:0] sp, logic [15:0] dp,
                                  logic [HdrLenW-1:0] hb, logic st);
    rec_t r;
    r.total_length   = tot;
    r.source_address = sa;
    r.dest_address   = da;
    r.source_port    = sp;
    r.dest_port      = dp;
    r.header_bytes   = hb;
    r.status         = st;
    return r;
  endfunction

  task automatic clear_capture();
    pkt_pos   = '0;
    pkt_hlen  = '0;
    pkt_tot   = '0;
    pkt_saddr = '0;
    pkt_daddr = '0;
    pkt_sport = '0;
    pkt_dport = '0;
  endtask

  // advance the capture state by one byte, returns a record on the last byte
  task automatic capture_byte(input logic [7:0] b, input logic l,
                              output bit done, output rec_t r);
    int p;
    int off;
    int need;
    done = 1'b0;
    r    = '0;
    p    = pkt_pos;
    // the header length decoded from byte 0 already applies to byte 0
    if (p == 0) pkt_hlen = {b[3:0] & IhlMask, 2'b00};
    if (p == TotLenHi) pkt_tot[15:8] = b;
    if (p == TotLenLo) pkt_tot[7:0] = b;
    if (p >= SrcStart && p < SrcStart + 4) pkt_saddr[8*(SrcStart+3-p) +: 8] = b;
    if (p >= DstStart && p < DstStart + 4) pkt_daddr[8*(DstStart+3-p) +: 8] = b;
    // port bytes may overlap header bytes when the header is short
    if (p >= int'(pkt_hlen) && p - int'(pkt_hlen) < PortBytes) begin
      off = p - int'(pkt_hlen);
      case (off)
        0:       pkt_sport[15:8] = b;
        1:       pkt_sport[7:0]  = b;
        2:       pkt_dport[15:8] = b;
        default: pkt_dport[7:0]  = b;
      endcase
    end
    // byte count saturates
    if (pkt_pos < IdxMax) pkt_pos = pkt_pos + 1'b1;
    if (l) begin
      need = int'(pkt_hlen) + PortBytes;
      if (need < MinHdrBytes) need = MinHdrBytes;
      r    = mk_rec(pkt_tot, pkt_saddr, pkt_daddr, pkt_sport, pkt_dport, pkt_hlen,
                    int'(pkt_pos) < need);
      done = 1'b1;
      clear_capture();
    end
  endtask

  // offer one byte, wait for its transaction, then record the prediction
  task automatic send_byte(input logic [7:0] b, input logic l, input bit typed,
                           input rec_t typed_rec);
    int   gap;
    bit   done;
    rec_t r;
    gap = (!src_calm && $urandom_range(0, 2) == 0) ? gap_len() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= l;
    do @(posedge clk_i); while (!s_axis_tready);
    capture_byte(b, l, done, r);
    if (done) pending_recs = {pending_recs, (typed ? typed_rec : r)};
  endtask

  task automatic add_row(logic [7:0] b, logic l, bit typed, rec_t r);
    stim_row_t row;
    row.data  = b;
    row.last  = l;
    row.typed = typed;
    row.rec   = r;
    dir_rows = {dir_rows, row};
  endtask

  // receiver stalls, with calm stretches
  always @(posedge clk_i) begin
    cyc++;
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if (cyc[8:7] != 2'b11 && $urandom_range(0, 3) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left = gap_len() - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // record checker
  always @(posedge clk_i) begin
    rec_t exp_rec;
    rec_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.total_length   = m_axis_tdata[15:0];
      got.source_address = m_axis_tdata[47:16];
      got.dest_address   = m_axis_tdata[79:48];
      got.source_port    = m_axis_tdata[95:80];
      got.dest_port      = m_axis_tdata[111:96];
      got.header_bytes   = m_axis_tdata[117:112];
      got.status         = m_axis_tuser;
      if (pending_recs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected record at %0t: %p", $realtime, got);
      end else begin
        exp_rec = pending_recs.pop_front();
        if (got.total_length   !== exp_rec.total_length   ||
            got.source_address !== exp_rec.source_address ||
            got.dest_address   !== exp_rec.dest_address   ||
            got.source_port    !== exp_rec.source_port    ||
            got.dest_port      !== exp_rec.dest_port      ||
            got.header_bytes   !== exp_rec.header_bytes   ||
            got.status         !== exp_rec.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("record mismatch at %0t\n  expected %p\n  actual   %p",
                     $realtime, exp_rec, got);
        end
      end
    end
  end

  // run limit
  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

  // stimulus
  initial begin
    int   n_bytes;
    int   n_pkts;
    int   hl;
    int   need;
    int   len;
    int   kind;
    logic [7:0] b0;
    clear_capture();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table: lone bytes with typed records, then a full
    // packet whose ports overlap the header
    add_row(8'h45, 1'b1, 1'b1, mk_rec(16'h0, 32'h0, 32'h0, 16'h0, 16'h0, 6'd20, 1'b1));
    add_row(8'hf0, 1'b1, 1'b1, mk_rec(16'h0, 32'h0, 32'h0, 16'hf000, 16'h0, 6'd0, 1'b1));
    add_row(8'hff, 1'b1, 1'b1, mk_rec(16'h0, 32'h0, 32'h0, 16'h0, 16'h0, 6'd60, 1'b1));
    add_row(8'h40, 1'b0, 1'b0, '0);
    for (int i = 1; i < 20; i++) begin
      add_row(i == 10 ? 8'h00 : 8'(i * 37 + 11), i == 19, 1'b0, '0);
    end
    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].rec);
    end

    // random packets, mostly well formed
    n_bytes = 0;
    n_pkts  = 0;
    while (n_bytes < ByteTarget) begin
      src_calm = ($urandom_range(0, 3) == 0);
      b0 = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 3) != 0) b0[7:4] = 4'h4;
      if ($urandom_range(0, 2) == 0) b0[3:0] = 4'h5;
      hl   = b0[3:0] * 4;
      need = (hl + 4 > MinHdrBytes) ? hl + 4 : MinHdrBytes;
      kind = $urandom_range(0, 19);
      if (kind < 13)      len = need + $urandom_range(0, 8);
      else if (kind < 17) len = $urandom_range(1, need - 1);
      else if (kind < 19) len = $urandom_range(1, 64);
      else                len = $urandom_range(64, 200);
      for (int i = 0; i < len; i++) begin
        send_byte(i == 0 ? b0 : 8'($urandom_range(0, 255)), i == len - 1, 1'b0, '0);
      end
      n_bytes += len;
      n_pkts++;
      // one hold-off until every record has drained
      if (n_pkts == 20) begin
        s_axis_tvalid <= 1'b0;
        while (pending_recs.size() > 0) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;

    // drain and settle
    while (pending_recs.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/iphpe_pkg.sv
src/iphpe_obuf.sv
src/ipv4_header_port_extractor_core.sv
verif/ipv4_header_port_extractor_core_tb.sv
